### rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, constants and the microcode program of the modular inverse
// block (extended Euclidean algorithm on a shared bit-serial divider).
// ----------------------------------------------------------------------------
package mie_pkg;

    // Fixed widths of the channel fields
    localparam int FIELD_W   = 32;
    // Default operand width
    localparam int MIE_WIDTH = 32;

    // Microcode addressing
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_TEST     = 3'd1;
    localparam step_t STEP_DIV_INIT = 3'd2;
    localparam step_t STEP_DIV_LOOP = 3'd3;
    localparam step_t STEP_UPDATE   = 3'd4;
    localparam step_t STEP_MOD_INIT = 3'd5;
    localparam step_t STEP_MOD_LOOP = 3'd6;
    localparam step_t STEP_EMIT     = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_MOD_INIT,
        OP_EMIT
    } op_t;

    // Wait and branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_REQ_VALID,
        COND_R2_ZERO,
        COND_DIV_MORE,
        COND_NOT_OK,
        COND_OUT_FREE
    } cond_t;

    // One control word of the program
    typedef struct packed {
        op_t   op;
        cond_t wait_c;
        cond_t br_c;
        step_t target;
    } cw_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic fire;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic r2_zero;
        logic div_more;
        logic not_ok;
        logic out_free;
    } stat_t;

    // Microcode ROM: the step stalls until wait_c holds, then executes op
    // and jumps to target when br_c holds, else falls through.
    function automatic cw_t mie_ucode(input step_t step);
        cw_t cw;
        case (step)
            STEP_IDLE:     cw = '{OP_LOAD,     COND_REQ_VALID, COND_NEVER,    STEP_TEST};
            STEP_TEST:     cw = '{OP_NOP,      COND_ALWAYS,    COND_R2_ZERO,  STEP_MOD_INIT};
            STEP_DIV_INIT: cw = '{OP_DIV_INIT, COND_ALWAYS,    COND_NEVER,    STEP_DIV_LOOP};
            STEP_DIV_LOOP: cw = '{OP_DIV_STEP, COND_ALWAYS,    COND_DIV_MORE, STEP_DIV_LOOP};
            STEP_UPDATE:   cw = '{OP_UPDATE,   COND_ALWAYS,    COND_ALWAYS,   STEP_TEST};
            STEP_MOD_INIT: cw = '{OP_MOD_INIT, COND_ALWAYS,    COND_NOT_OK,   STEP_EMIT};
            STEP_MOD_LOOP: cw = '{OP_DIV_STEP, COND_ALWAYS,    COND_DIV_MORE, STEP_MOD_LOOP};
            STEP_EMIT:     cw = '{OP_EMIT,     COND_OUT_FREE,  COND_ALWAYS,   STEP_IDLE};
            default:       cw = '{OP_NOP,      COND_ALWAYS,    COND_ALWAYS,   STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

### rtl/mie_req_if.sv
// ----------------------------------------------------------------------------
// mie_req_if
// Request channel: modulus and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mie_req_if;
    logic                         valid;
    logic                         ready;
    logic [mie_pkg::FIELD_W-1:0]  modulus;
    logic [mie_pkg::FIELD_W-1:0]  value;

    modport source (output valid, output modulus, output value, input ready);
    modport sink   (input valid, input modulus, input value, output ready);
endinterface

### rtl/mie_rsp_if.sv
// ----------------------------------------------------------------------------
// mie_rsp_if
// Response channel: gcd, inverse flag and inverse with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mie_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mie_pkg::FIELD_W-1:0]  divisor;
    logic                         has_inverse;
    logic [mie_pkg::FIELD_W-1:0]  inverse;

    modport source (output valid, output divisor, output has_inverse, output inverse,
                    input ready);
    modport sink   (input valid, input divisor, input has_inverse, input inverse,
                    output ready);
endinterface

### rtl/mie_sequencer.sv
// ----------------------------------------------------------------------------
// mie_sequencer
// Step counter over the microcode ROM: evaluates wait and branch
// conditions and issues one operation per cycle to the datapath whenever the step's wait condition holds.
// ----------------------------------------------------------------------------
module mie_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  mie_pkg::stat_t  stat,
    output mie_pkg::ctl_t   ctl
);
    import mie_pkg::*;

    step_t step_reg;
    step_t step_next;
    cw_t   cw;
    logic  go;
    logic  take_br;

    function automatic logic cond_eval(input cond_t c, input logic rv, input stat_t s);
        logic res;
        case (c)
            COND_ALWAYS:    res = 1'b1;
            COND_NEVER:     res = 1'b0;
            COND_REQ_VALID: res = rv;
            COND_R2_ZERO:   res = s.r2_zero;
            COND_DIV_MORE:  res = s.div_more;
            COND_NOT_OK:    res = s.not_ok;
            COND_OUT_FREE:  res = s.out_free;
            default:        res = 1'b0;
        endcase
        return res;
    endfunction

    // Fetch the control word and resolve the conditions
    always_comb
    begin
        cw      = mie_ucode(step_reg);
        go      = cond_eval(cw.wait_c, req_valid, stat);
        take_br = cond_eval(cw.br_c, req_valid, stat);
        ctl.op   = cw.op;
        ctl.fire = go;
        if (!go)
        begin
            step_next = step_reg;
        end
        else if (take_br)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // A taken request always leads into the loop test
    a_load_to_test: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && ctl.op == OP_LOAD) |=> (step_reg == STEP_TEST))
        else $error("load not followed by loop test");

    // The response step stalls only while the output is occupied
    a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_EMIT && !stat.out_free) |=> (step_reg == STEP_EMIT))
        else $error("response step left while output busy");

    // Without a request the sequencer stays in the load step
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_IDLE && !req_valid) |=> (step_reg == STEP_IDLE))
        else $error("load step left without a request");

endmodule

### rtl/mie_datapath.sv
// ----------------------------------------------------------------------------
// mie_datapath
// Euclid registers, sign-magnitude coefficients, a shared restoring divider
// with one quotient bit per cycle, and the response output register.
// ----------------------------------------------------------------------------
module mie_datapath #(
    parameter int WIDTH = mie_pkg::MIE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mie_pkg::ctl_t                ctl,
    output mie_pkg::stat_t               stat,
    input  logic [mie_pkg::FIELD_W-1:0]  req_modulus,
    input  logic [mie_pkg::FIELD_W-1:0]  req_value,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [mie_pkg::FIELD_W-1:0]  rsp_divisor,
    output logic                         rsp_has_inverse,
    output logic [mie_pkg::FIELD_W-1:0]  rsp_inverse
);
    import mie_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    // Euclid state
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] r1_reg;
    logic [WIDTH-1:0] r2_reg;
    logic             t1neg_reg;
    logic [WIDTH-1:0] t1mag_reg;
    logic             t2neg_reg;
    logic [WIDTH-1:0] t2mag_reg;

    // Divider state
    logic [WIDTH-1:0] dq_reg;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] prod_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register
    logic                rsp_valid_reg;
    logic [FIELD_W-1:0]  rsp_divisor_reg;
    logic                rsp_has_inverse_reg;
    logic [FIELD_W-1:0]  rsp_inverse_reg;

    logic [WIDTH:0]   rem_sh;
    logic             q_bit;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] prod_next;
    logic             pneg;
    logic             yneg;
    logic             tneg;
    logic [WIDTH-1:0] tmag;
    logic             ok;
    logic [WIDTH-1:0] inv;
    logic             out_free;
    logic             do_emit;

    // Divider bit step: shift in the next dividend bit, trial-subtract,
    // and accumulate the quotient times t2 alongside
    always_comb
    begin
        rem_sh    = {rem_reg, dq_reg[WIDTH-1]};
        q_bit     = (rem_sh >= {1'b0, dsr_reg});
        rem_next  = q_bit ? WIDTH'(rem_sh - {1'b0, dsr_reg}) : WIDTH'(rem_sh);
        prod_next = {prod_reg[WIDTH-2:0], 1'b0} + (q_bit ? t2mag_reg : '0);
    end

    // Coefficient update: t = t1 - sign(t2) * prod
    always_comb
    begin
        pneg = t2neg_reg && (prod_reg != '0);
        yneg = !pneg;
        if (t1neg_reg == yneg)
        begin
            tneg = t1neg_reg;
            tmag = t1mag_reg + prod_reg;
        end
        else if (t1mag_reg >= prod_reg)
        begin
            tneg = t1neg_reg;
            tmag = t1mag_reg - prod_reg;
        end
        else
        begin
            tneg = yneg;
            tmag = prod_reg - t1mag_reg;
        end
        if (tmag == '0)
        begin
            tneg = 1'b0;
        end
    end

    // Result: remainder of |t1| mod n, flipped when t1 is negative
    always_comb
    begin
        ok = (r1_reg == WIDTH'(1)) && (n_reg != '0);
        if (!ok)
        begin
            inv = '0;
        end
        else if (t1neg_reg && (rem_reg != '0))
        begin
            inv = n_reg - rem_reg;
        end
        else
        begin
            inv = rem_reg;
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign do_emit  = ctl.fire && (ctl.op == OP_EMIT);

    always_comb
    begin
        stat.r2_zero  = (r2_reg == '0);
        stat.div_more = (cnt_reg != CNT_W'(1));
        stat.not_ok   = !ok;
        stat.out_free = out_free;
    end

    // Execute the current operation
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    n_reg     <= WIDTH'(req_modulus);
                    r1_reg    <= WIDTH'(req_modulus);
                    r2_reg    <= WIDTH'(req_value);
                    t1neg_reg <= 1'b0;
                    t1mag_reg <= '0;
                    t2neg_reg <= 1'b0;
                    t2mag_reg <= WIDTH'(1);
                end
                OP_DIV_INIT:
                begin
                    dq_reg   <= r1_reg;
                    dsr_reg  <= r2_reg;
                    rem_reg  <= '0;
                    prod_reg <= '0;
                    cnt_reg  <= CNT_W'(WIDTH);
                end
                OP_MOD_INIT:
                begin
                    dq_reg   <= t1mag_reg;
                    dsr_reg  <= n_reg;
                    rem_reg  <= '0;
                    prod_reg <= '0;
                    cnt_reg  <= CNT_W'(WIDTH);
                end
                OP_DIV_STEP:
                begin
                    dq_reg   <= {dq_reg[WIDTH-2:0], 1'b0};
                    rem_reg  <= rem_next;
                    prod_reg <= prod_next;
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                end
                OP_UPDATE:
                begin
                    r1_reg    <= r2_reg;
                    r2_reg    <= rem_reg;
                    t1neg_reg <= t2neg_reg;
                    t1mag_reg <= t2mag_reg;
                    t2neg_reg <= tneg;
                    t2mag_reg <= tmag;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Capture the response payload
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            rsp_divisor_reg     <= FIELD_W'(r1_reg);
            rsp_has_inverse_reg <= ok;
            rsp_inverse_reg     <= FIELD_W'(inv);
        end
    end

    // Hold the response until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (do_emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_divisor     = rsp_divisor_reg;
    assign rsp_has_inverse = rsp_has_inverse_reg;
    assign rsp_inverse     = rsp_inverse_reg;

    // Divider never runs on a zero divisor or an exhausted count
    a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && ctl.op == OP_DIV_STEP) |-> (dsr_reg != '0 && cnt_reg != '0))
        else $error("divider step with zero divisor or count");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && ctl.op == OP_DIV_STEP) |=> (rem_reg < dsr_reg))
        else $error("partial remainder out of range");

    // A new response never overwrites one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before transfer");

endmodule

### rtl/modular_inverse_ext_euclid_top.sv
// Each Euclid round is one full pass of the bit-serial divider, with about 1.44*WIDTH
//   rounds at worst; when no inverse exists, the final reduction mod n is skipped.
// Throughput: one item at a time; the next request is taken once the response
//   is loaded into the output register.
// Reset: asynchronous, active low; clears the step counter and response valid.
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top
// Modular inverse by the extended Euclidean algorithm, run by a microcoded
// sequencer over a datapath with one shared restoring divider.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = mie_pkg::MIE_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    mie_req_if.sink    req,
    mie_rsp_if.source  rsp
);
    import mie_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Ready only in the load step
    assign req.ready = (ctl.op == OP_LOAD);

    mie_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .ctl       (ctl)
    );

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .req_modulus     (req.modulus),
        .req_value       (req.value),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_divisor     (rsp.divisor),
        .rsp_has_inverse (rsp.has_inverse),
        .rsp_inverse     (rsp.inverse)
    );

endmodule

### sim/mie_inverse_check.sv
// ----------------------------------------------------------------------------
// mie_inverse_check
// Watches the request and response channels of the modular inverse block.
// Every request transfer is run through an extended Euclid model to get the
// expected gcd, inverse flag and inverse. Every response transfer is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module mie_inverse_check (
    input  logic clk,
    input  logic rst_n,
    mie_req_if   req,
    mie_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mie_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] divisor;
        logic               has_inverse;
        logic [FIELD_W-1:0] inverse;
    } inv_result_t;

    inv_result_t expected_inverses[$];

    // Extended Euclid with a sign-magnitude coefficient; 64-bit holds all
    // intermediate products since the coefficient never exceeds the modulus
    function automatic inv_result_t euclid_inverse(input logic [FIELD_W-1:0] n_in,
                                                   input logic [FIELD_W-1:0] a_in);
        logic [63:0] r_prev;
        logic [63:0] r_cur;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] prod;
        logic [63:0] c_prev_mag;
        logic [63:0] c_cur_mag;
        logic [63:0] c_next_mag;
        logic [63:0] red;
        logic        c_prev_neg;
        logic        c_cur_neg;
        logic        c_next_neg;
        logic        prod_neg;
        inv_result_t res;

        r_prev     = 64'(n_in);
        r_cur      = 64'(a_in);
        c_prev_neg = 1'b0;
        c_prev_mag = 64'd0;
        c_cur_neg  = 1'b0;
        c_cur_mag  = 64'd1;
        while (r_cur != 64'd0)
        begin
            quot = r_prev / r_cur;
            rem  = r_prev - quot * r_cur;
            prod = quot * c_cur_mag;
            prod_neg = c_cur_neg && (prod != 64'd0);
            // next coefficient = previous - quot * current
            if (c_prev_neg != prod_neg)
            begin
                c_next_neg = c_prev_neg;
                c_next_mag = c_prev_mag + prod;
            end
            else if (c_prev_mag >= prod)
            begin
                c_next_neg = c_prev_neg;
                c_next_mag = c_prev_mag - prod;
            end
            else
            begin
                c_next_neg = !prod_neg;
                c_next_mag = prod - c_prev_mag;
            end
            if (c_next_mag == 64'd0)
                c_next_neg = 1'b0;
            r_prev     = r_cur;
            r_cur      = rem;
            c_prev_neg = c_cur_neg;
            c_prev_mag = c_cur_mag;
            c_cur_neg  = c_next_neg;
            c_cur_mag  = c_next_mag;
        end

        res.divisor     = r_prev[FIELD_W-1:0];
        res.has_inverse = (r_prev == 64'd1) && (n_in != '0);
        res.inverse     = '0;
        if (res.has_inverse)
        begin
            // normalize the coefficient into 0..n-1
            red = c_prev_mag % 64'(n_in);
            if (c_prev_neg && red != 64'd0)
                res.inverse = FIELD_W'(64'(n_in) - red);
            else
                res.inverse = red[FIELD_W-1:0];
        end
        return res;
    endfunction

    // Compare response transfers first, then queue the new request transfer
    always @(posedge clk or negedge rst_n)
    begin
        inv_result_t want;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            expected_inverses.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    errs++;
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    if (rsp.divisor !== want.divisor)
                    begin
                        $error("divisor: expected %0d, got %0d", want.divisor, rsp.divisor);
                        errs++;
                    end
                    if (rsp.has_inverse !== want.has_inverse)
                    begin
                        $error("has_inverse: expected %0b, got %0b",
                               want.has_inverse, rsp.has_inverse);
                        errs++;
                    end
                    if (rsp.inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0d, got %0d", want.inverse, rsp.inverse);
                        errs++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_inverses.push_back(euclid_inverse(req.modulus, req.value));
            fail_count <= fail_count + errs;
            pending    <= expected_inverses.size();
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the modular inverse block. Drives a directed set of
// corner operands, then random operand pairs (worst-case Fibonacci pairs,
// shared factors, tiny and full-width moduli), with random gaps on both
// channels and one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mie_pkg::*;

    localparam int RANDOM_ITEMS  = 560;
    localparam int CYCLE_LIMIT   = 6_000_000;
    // longer than one worst-case request-to-response latency
    localparam int DRAIN_CYCLES  = 2500;
    localparam int HOLD_CYCLES   = 5000;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int DIRECTED_LEN  = 22;

    localparam logic [63:0] DIRECTED_OPERANDS [DIRECTED_LEN] = '{
        {32'd1,          32'd0},
        {32'd1,          32'd5},
        {32'd1,          32'hFFFF_FFFF},
        {32'd7,          32'd0},
        {32'd0,          32'd0},
        {32'd0,          32'd12345},
        {32'hFFFF_FFFF,  32'd0},
        {32'hFFFF_FFFF,  32'hFFFF_FFFF},
        {32'hFFFF_FFFF,  32'hFFFF_FFFE},
        {32'hFFFF_FFFE,  32'hFFFF_FFFF},
        {32'd10,         32'd3},
        {32'd3,          32'd10},
        {32'd12,         32'd8},
        {32'hFFFF_FFFB,  32'd2},
        {32'd2971215073, 32'd1836311903},
        {32'd1836311903, 32'd2971215073},
        {32'd13,         32'd13},
        {32'd2,          32'd1},
        {32'd17,         32'd16},
        {32'h8000_0000,  32'd3},
        {32'h8000_0000,  32'h7FFF_FFFF},
        {32'd6,          32'd4}
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    int unsigned items_sent;
    int unsigned send_pause_pct;
    int unsigned ready_pause_pct;
    int unsigned ready_gap;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned cycle_count;
    logic [31:0] fib [0:47];

    mie_req_if req_ch ();
    mie_rsp_if rsp_ch ();

    modular_inverse_ext_euclid_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mie_inverse_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    // Response ready: random pauses in changing modes, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(100, 400);
                case ($urandom_range(0, 2))
                    0:       ready_pause_pct = 0;
                    1:       ready_pause_pct = 15;
                    default: ready_pause_pct = 50;
                endcase
            end
            else
            begin
                mode_left--;
            end
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < ready_pause_pct)
            begin
                ready_gap = gap_len() - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request from a falling edge, hold it until the transfer, then
    // sometimes idle for a random gap; returns on a falling edge
    task automatic offer_operands(input logic [31:0] modulus, input logic [31:0] value);
        int unsigned gap;
        req_ch.valid   <= 1'b1;
        req_ch.modulus <= modulus;
        req_ch.value   <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        gap = ($urandom_range(0, 99) < send_pause_pct) ? gap_len() : 0;
        if (gap > 0)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.modulus <= $urandom;
            req_ch.value   <= $urandom;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] modulus;
        logic [31:0] value;
        int unsigned k;
        int unsigned g;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.modulus = '0;
        req_ch.value   = '0;
        fib[0] = 32'd0;
        fib[1] = 32'd1;
        for (int i = 2; i < 48; i++)
            fib[i] = fib[i-1] + fib[i-2];

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corner operands: modulus one, zero value, zero modulus, value above
        // modulus, full-width extremes, worst-case Fibonacci pair
        send_pause_pct = 30;
        for (int i = 0; i < DIRECTED_LEN; i++)
            offer_operands(DIRECTED_OPERANDS[i][63:32], DIRECTED_OPERANDS[i][31:0]);

        // Random operand pairs drawn from several shapes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       send_pause_pct = 0;
                    1:       send_pause_pct = 20;
                    default: send_pause_pct = 70;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    modulus = $urandom;
                    value   = $urandom;
                end
                2:
                begin
                    modulus = $urandom_range(1, 255);
                    value   = $urandom_range(0, 255);
                end
                3:
                begin
                    modulus = $urandom_range(1, 32'hFFFF_FFFF);
                    value   = $urandom % modulus;
                    if ($urandom_range(0, 1) == 1)
                        {modulus, value} = {value | 32'd1, modulus};
                end
                4:
                begin
                    k = $urandom_range(2, 46);
                    modulus = fib[k+1];
                    value   = fib[k];
                    if ($urandom_range(0, 1) == 1)
                        {modulus, value} = {value, modulus};
                end
                5:
                begin
                    g = $urandom_range(2, 1000);
                    modulus = g * $urandom_range(1, 4_000_000);
                    value   = g * $urandom_range(0, 4_000_000);
                end
                6:
                begin
                    modulus = ($urandom_range(0, 1) == 1) ? 32'd1 : $urandom_range(1, 32'hFFFF_FFFF);
                    value   = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom;
                end
                7:
                begin
                    modulus = $urandom | 32'h8000_0000;
                    value   = $urandom;
                end
                8:
                begin
                    modulus = 32'hFFFF_FFFB;
                    value   = $urandom;
                end
                default:
                begin
                    modulus = $urandom_range(2, 32'hFFFF_FFFF);
                    value   = ($urandom_range(0, 1) == 1) ? modulus - 32'd1
                                                          : modulus + $urandom_range(0, 1000);
                end
            endcase
            offer_operands(modulus, value);
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then watch for stray ones
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
